// ===== rtl/kte_pkg.sv =====
package kte_pkg;

    localparam int FIELD_W         = 16;
    localparam int MAX_SYMBOL_BITS = 16;
    localparam int MAX_OUTPUT_BITS = 16;
    localparam int DEF_NUM_STATES      = 64;
    localparam int DEF_NUM_TRANSITIONS = 256;

    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_WIDTH = 2'd2;

    typedef enum logic [1:0] {
        CMD_WR_TRANS = 2'd0,
        CMD_WR_RANGE = 2'd1,
        CMD_RESTART  = 2'd2,
        CMD_STEP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_HALTED  = 2'd2,
        ST_LOAD    = 2'd3
    } status_t;

    // first member sits in the top bits
    typedef struct packed {
        logic [2:0]  pad;
        logic [15:0] symbol_care;
        logic [15:0] symbol_value;
        logic [8:0]  range_count;
        logic [7:0]  range_start;
        logic [5:0]  load_next_state;
        logic [15:0] load_out_dash;
        logic [15:0] load_out_value;
        logic [15:0] pattern_care;
        logic [15:0] pattern_value;
        logic [5:0]  state_index;
        logic [7:0]  entry_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  pad;
        logic [5:0]  state_after;
        logic [15:0] out_dash;
        logic [15:0] out_value;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic wr_trans;
        logic wr_range;
        logic restart;
        logic rd_range;
        logic scan_start;
        logic scan_next;
        logic take_match;
        logic no_match;
        logic halt_ign;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic halted;
        logic range_empty;
        logic match;
        logic scan_end;
        logic out_free;
    } dp_stat_t;

    function automatic logic [FIELD_W-1:0] low_mask(input logic [4:0] w, input int limit);
        logic [FIELD_W-1:0] m;
        m = '0;
        for (int i = 0; i < FIELD_W; i++) begin
            m[i] = (i < int'(w)) && (i < limit);
        end
        return m;
    endfunction

endpackage

// ===== rtl/kte_ctrl.sv =====
module kte_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  kte_pkg::dp_stat_t   stat,
    output kte_pkg::dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_RANGE  = 5'b00100,
        S_SCAN   = 5'b01000,
        S_FINISH = 5'b10000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_FINISH;
                unique case (stat.cmd)
                    kte_pkg::CMD_WR_TRANS: cmd.wr_trans = 1'b1;
                    kte_pkg::CMD_WR_RANGE: cmd.wr_range = 1'b1;
                    kte_pkg::CMD_RESTART:  cmd.restart  = 1'b1;
                    kte_pkg::CMD_STEP: begin
                        if (stat.halted) begin
                            cmd.halt_ign = 1'b1;
                        end else begin
                            cmd.rd_range = 1'b1;
                            state_next   = S_RANGE;
                        end
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_RANGE: begin
                if (stat.range_empty) begin
                    cmd.no_match = 1'b1;
                    state_next   = S_FINISH;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                priority if (stat.match) begin
                    cmd.take_match = 1'b1;
                    state_next     = S_FINISH;
                end else if (stat.scan_end) begin
                    cmd.no_match = 1'b1;
                    state_next   = S_FINISH;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/kte_datapath.sv =====
module kte_datapath #(
    parameter int NUM_STATES      = kte_pkg::DEF_NUM_STATES,
    parameter int NUM_TRANSITIONS = kte_pkg::DEF_NUM_TRANSITIONS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [kte_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic [1:0]                        s_tuser,
    input  logic                              cfg_valid,
    input  logic [kte_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kte_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [kte_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [1:0]                        m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  kte_pkg::dp_cmd_t                  cmd,
    output kte_pkg::dp_stat_t                 stat
);

    localparam int TA_W   = $clog2(NUM_TRANSITIONS);
    localparam int SA_W   = $clog2(NUM_STATES);
    localparam int SCAN_W = ($clog2(NUM_TRANSITIONS + 1) > 10) ?
                            $clog2(NUM_TRANSITIONS + 1) : 10;

    logic [31:0] pat_mem [NUM_TRANSITIONS];
    logic [37:0] act_mem [NUM_TRANSITIONS];
    logic [16:0] rng_mem [NUM_STATES];

    logic [31:0] pat_rd_reg;
    logic [37:0] act_rd_reg;
    logic [16:0] rng_rd_reg;

    kte_pkg::in_item_t  item_reg;
    kte_pkg::cmd_t      cmd_code_reg;
    kte_pkg::out_item_t out_reg;
    kte_pkg::status_t   out_status_reg;
    kte_pkg::status_t   res_status_reg;
    logic               out_valid_reg;
    logic [15:0]        res_value_reg;
    logic [15:0]        res_dash_reg;

    logic [5:0]         start_state_reg;
    logic [4:0]         in_width_reg;
    logic [4:0]         out_width_reg;
    logic [5:0]         cur_state_reg;
    logic               halted_reg;
    logic               cs_ok_reg;
    logic [SCAN_W-1:0]  scan_idx_reg;
    logic [SCAN_W-1:0]  last_reg;

    logic [TA_W+7:0]    ent_ext;
    logic [SA_W+5:0]    sidx_ext;
    logic [SA_W+5:0]    cs_ext;
    logic               ent_ok;
    logic               sidx_ok;
    logic [SCAN_W-1:0]  first_ext;
    logic [SCAN_W-1:0]  sum_ext;
    logic [SCAN_W-1:0]  last_calc;
    logic [TA_W-1:0]    rd_addr;
    logic               rd_en;
    logic [15:0]        imask;
    logic [15:0]        omask;
    logic [15:0]        pv;
    logic [15:0]        pc;
    logic [15:0]        od;
    logic [15:0]        ov;
    logic               hit;

    assign ent_ext  = (TA_W + 8)'(item_reg.entry_index);
    assign sidx_ext = (SA_W + 6)'(item_reg.state_index);
    assign cs_ext   = (SA_W + 6)'(cur_state_reg);
    assign ent_ok   = {24'd0, item_reg.entry_index} < 32'(NUM_TRANSITIONS);
    assign sidx_ok  = {26'd0, item_reg.state_index} < 32'(NUM_STATES);

    // range clamp to the store size
    assign first_ext = SCAN_W'(rng_rd_reg[7:0]);
    assign sum_ext   = first_ext + SCAN_W'(rng_rd_reg[16:8]);
    assign last_calc = (sum_ext > SCAN_W'(NUM_TRANSITIONS)) ? SCAN_W'(NUM_TRANSITIONS) : sum_ext;

    assign rd_en   = cmd.scan_start | cmd.scan_next;
    assign rd_addr = cmd.scan_start ? first_ext[TA_W-1:0] : scan_idx_reg[TA_W-1:0];

    assign imask = kte_pkg::low_mask(in_width_reg, kte_pkg::MAX_SYMBOL_BITS);
    assign omask = kte_pkg::low_mask(out_width_reg, kte_pkg::MAX_OUTPUT_BITS);
    assign pv    = pat_rd_reg[15:0];
    assign pc    = pat_rd_reg[31:16];
    assign hit   = (((item_reg.symbol_value ^ pv) & item_reg.symbol_care & pc & imask) == '0);
    assign od    = act_rd_reg[31:16] & omask;
    assign ov    = act_rd_reg[15:0] & omask & ~od;

    assign stat.cmd         = cmd_code_reg;
    assign stat.halted      = halted_reg;
    assign stat.range_empty = !cs_ok_reg || (first_ext >= last_calc);
    assign stat.match       = hit;
    assign stat.scan_end    = scan_idx_reg >= last_reg;
    assign stat.out_free    = !out_valid_reg || m_tready;

    // memories
    always_ff @(posedge aclk) begin
        if (cmd.wr_trans && ent_ok) begin
            pat_mem[ent_ext[TA_W-1:0]] <= {item_reg.pattern_care, item_reg.pattern_value};
            act_mem[ent_ext[TA_W-1:0]] <= {item_reg.load_next_state, item_reg.load_out_dash,
                                           item_reg.load_out_value};
        end
        if (rd_en) begin
            pat_rd_reg <= pat_mem[rd_addr];
            act_rd_reg <= act_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_range && sidx_ok) begin
            rng_mem[sidx_ext[SA_W-1:0]] <= {item_reg.range_count, item_reg.range_start};
        end
        if (cmd.rd_range) begin
            rng_rd_reg <= rng_mem[cs_ext[SA_W-1:0]];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_state_reg <= '0;
            in_width_reg    <= 5'd16;
            out_width_reg   <= 5'd16;
            cur_state_reg   <= '0;
            halted_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    kte_pkg::CFG_START_STATE:  start_state_reg <= cfg_data;
                    kte_pkg::CFG_INPUT_WIDTH:  in_width_reg    <= cfg_data[4:0];
                    kte_pkg::CFG_OUTPUT_WIDTH: out_width_reg   <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (cmd.restart) begin
                cur_state_reg <= start_state_reg;
                halted_reg    <= 1'b0;
            end else if (cmd.take_match) begin
                cur_state_reg <= act_rd_reg[37:32];
            end else if (cmd.no_match) begin
                halted_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg     <= kte_pkg::in_item_t'(s_tdata);
            cmd_code_reg <= kte_pkg::cmd_t'(s_tuser);
        end
        if (cmd.rd_range) begin
            cs_ok_reg <= {26'd0, cur_state_reg} < 32'(NUM_STATES);
        end
        if (cmd.scan_start) begin
            scan_idx_reg <= first_ext + SCAN_W'(1);
            last_reg     <= last_calc;
        end else if (cmd.scan_next) begin
            scan_idx_reg <= scan_idx_reg + SCAN_W'(1);
        end
        priority if (cmd.take_match) begin
            res_value_reg  <= ov;
            res_dash_reg   <= od;
            res_status_reg <= kte_pkg::ST_OK;
        end else if (cmd.wr_trans || cmd.wr_range) begin
            res_value_reg  <= '0;
            res_dash_reg   <= '0;
            res_status_reg <= kte_pkg::ST_LOAD;
        end else if (cmd.restart) begin
            res_value_reg  <= '0;
            res_dash_reg   <= '0;
            res_status_reg <= kte_pkg::ST_OK;
        end else if (cmd.no_match) begin
            res_value_reg  <= '0;
            res_dash_reg   <= '0;
            res_status_reg <= kte_pkg::ST_NOMATCH;
        end else if (cmd.halt_ign) begin
            res_value_reg  <= '0;
            res_dash_reg   <= '0;
            res_status_reg <= kte_pkg::ST_HALTED;
        end
        if (cmd.out_load) begin
            out_reg.pad         <= '0;
            out_reg.state_after <= cur_state_reg;
            out_reg.out_dash    <= res_dash_reg;
            out_reg.out_value   <= res_value_reg;
            out_status_reg      <= res_status_reg;
        end
    end

    assign m_tdata  = out_reg;
    assign m_tuser  = out_status_reg;
    assign m_tvalid = out_valid_reg;

endmodule

// ===== rtl/kiss2_table_fsm_engine.sv =====
// channel  | direction | transfer fields
// s_       | in        | tuser: cmd; tdata: command operands
// m_       | out       | tuser: status; tdata: out_value, out_dash, state_after
// cfg_     | in        | cfg_index: register, cfg_data: value (always ready)
//
// Loads, restart and halted steps pass through decode and finish to the result.
// A step passes through decode, range lookup, scan and finish, the scan reading
// transitions one per cycle through the single read port of the transition store.
// aresetn is synchronous; stores are not cleared, state and halt flag are.
// The output register holds a result while the next item is taken; a
// stalled m_ side blocks only the completion of that next item.
module kiss2_table_fsm_engine #(
    parameter int NUM_STATES      = kte_pkg::DEF_NUM_STATES,
    parameter int NUM_TRANSITIONS = kte_pkg::DEF_NUM_TRANSITIONS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // entry_index, state_index, pattern_value, pattern_care, load_out_value,
    // load_out_dash, load_next_state, range_start, range_count, symbol_value,
    // symbol_care, zero pad
    input  logic [kte_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic [1:0]                        s_tuser,   // cmd
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_value, out_dash, state_after, zero pad
    output logic [kte_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [1:0]                        m_tuser,   // status
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kte_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kte_pkg::CFG_DATA_W-1:0]    cfg_data
);

    kte_pkg::dp_cmd_t  dp_cmd;
    kte_pkg::dp_stat_t dp_stat;

    assign cfg_ready = 1'b1;

    kte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    kte_datapath #(
        .NUM_STATES      (NUM_STATES),
        .NUM_TRANSITIONS (NUM_TRANSITIONS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in progress");

    a_result_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({dp_cmd.wr_trans, dp_cmd.wr_range, dp_cmd.restart,
                  dp_cmd.take_match, dp_cmd.no_match, dp_cmd.halt_ign}))
        else $error("more than one result source in a cycle");

    a_dash_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[15:0] & m_tdata[31:16]) == 16'd0))
        else $error("output value set at a dash position");

    a_nomatch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != kte_pkg::ST_OK) |-> (m_tdata[31:0] == 32'd0))
        else $error("non-match result carries output bits");
`endif

endmodule

// ===== dv/tb_kiss2_table_fsm_engine.sv =====
module tb_kiss2_table_fsm_engine;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int NUM_SLOTS   = 256;

    typedef struct packed {
        kte_pkg::status_t status;
        logic [5:0]       state_after;
        logic [15:0]      out_dash;
        logic [15:0]      out_value;
    } fsm_result_t;

    class fsm_scoreboard;
        logic [15:0] pat_val  [NUM_SLOTS];
        logic [15:0] pat_care [NUM_SLOTS];
        logic [15:0] act_out  [NUM_SLOTS];
        logic [15:0] act_dash [NUM_SLOTS];
        logic [5:0]  act_next [NUM_SLOTS];
        bit          slot_done[NUM_SLOTS];
        logic [7:0]  rng_first[64];
        logic [8:0]  rng_count[64];
        bit          range_done[64];
        logic [5:0]  cur_state;
        bit          halted;
        logic [5:0]  start_state;
        logic [4:0]  in_width;
        logic [4:0]  out_width;
        fsm_result_t expected_q[$];
        int          mismatches;
        int          checked;
        int          n_steps;
        int          n_loads;
        int          n_restarts;
        int          n_nomatch;

        function new();
            cur_state   = '0;
            halted      = 1'b0;
            start_state = '0;
            in_width    = 5'd16;
            out_width   = 5'd16;
            foreach (slot_done[i]) slot_done[i] = 1'b0;
            foreach (range_done[i]) range_done[i] = 1'b0;
        endfunction

        function void write_reg(logic [kte_pkg::CFG_IDX_W-1:0] idx,
                                logic [kte_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                kte_pkg::CFG_START_STATE:  start_state = data;
                kte_pkg::CFG_INPUT_WIDTH:  in_width    = data[4:0];
                kte_pkg::CFG_OUTPUT_WIDTH: out_width   = data[4:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] width_mask(logic [4:0] w);
            logic [15:0] m;
            for (int i = 0; i < 16; i++) m[i] = (i < int'(w));
            return m;
        endfunction

        function int scan_last(logic [5:0] st);
            int last;
            last = int'(rng_first[st]) + int'(rng_count[st]);
            return (last > NUM_SLOTS) ? NUM_SLOTS : last;
        endfunction

        // true when a step would only touch written table entries
        function bit step_ready();
            if (halted) return 1'b1;
            if (!range_done[cur_state]) return 1'b0;
            for (int i = rng_first[cur_state]; i < scan_last(cur_state); i++)
                if (!slot_done[i]) return 1'b0;
            return 1'b1;
        endfunction

        function void note_input(kte_pkg::cmd_t c, kte_pkg::in_item_t it);
            fsm_result_t r;
            logic [15:0] imask;
            logic [15:0] omask;
            bit          found;
            int          last;
            r = '0;
            case (c)
                kte_pkg::CMD_WR_TRANS: begin
                    pat_val[it.entry_index]   = it.pattern_value;
                    pat_care[it.entry_index]  = it.pattern_care;
                    act_out[it.entry_index]   = it.load_out_value;
                    act_dash[it.entry_index]  = it.load_out_dash;
                    act_next[it.entry_index]  = it.load_next_state;
                    slot_done[it.entry_index] = 1'b1;
                    r.status = kte_pkg::ST_LOAD;
                    n_loads++;
                end
                kte_pkg::CMD_WR_RANGE: begin
                    rng_first[it.state_index]  = it.range_start;
                    rng_count[it.state_index]  = it.range_count;
                    range_done[it.state_index] = 1'b1;
                    r.status = kte_pkg::ST_LOAD;
                    n_loads++;
                end
                kte_pkg::CMD_RESTART: begin
                    cur_state = start_state;
                    halted    = 1'b0;
                    r.status  = kte_pkg::ST_OK;
                    n_restarts++;
                end
                default: begin
                    n_steps++;
                    if (halted) begin
                        r.status = kte_pkg::ST_HALTED;
                    end else begin
                        imask = width_mask(in_width);
                        omask = width_mask(out_width);
                        found = 1'b0;
                        last  = scan_last(cur_state);
                        for (int i = rng_first[cur_state]; i < last && !found; i++) begin
                            if ((((it.symbol_value ^ pat_val[i]) & it.symbol_care
                                  & pat_care[i]) & imask) == 16'h0) begin
                                r.out_dash  = act_dash[i] & omask;
                                r.out_value = act_out[i] & omask & ~r.out_dash;
                                cur_state   = act_next[i];
                                found       = 1'b1;
                            end
                        end
                        if (found) begin
                            r.status = kte_pkg::ST_OK;
                        end else begin
                            r.status = kte_pkg::ST_NOMATCH;
                            halted   = 1'b1;
                            n_nomatch++;
                        end
                    end
                end
            endcase
            r.state_after = cur_state;
            expected_q.push_back(r);
        endfunction

        function void check_result(kte_pkg::status_t st, kte_pkg::out_item_t o);
            fsm_result_t e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status=%0d value=%h dash=%h state=%0d",
                             st, o.out_value, o.out_dash, o.state_after);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (e.status !== st || e.out_value !== o.out_value ||
                e.out_dash !== o.out_dash || e.state_after !== o.state_after) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch on result %0d: exp status=%0d value=%h dash=%h ",
                              "state=%0d, got status=%0d value=%h dash=%h state=%0d"},
                             checked, e.status, e.out_value, e.out_dash, e.state_after,
                             st, o.out_value, o.out_dash, o.state_after);
            end
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [kte_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic [1:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [kte_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]                      m_tuser;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [kte_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [kte_pkg::CFG_DATA_W-1:0]  cfg_data;

    fsm_scoreboard sb = new();
    int            s_idle_pct;
    int            m_idle_pct;
    int            work_items;
    logic [5:0]    hot_states[8];

    kiss2_table_fsm_engine u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, sb.expected_q.size());
        $display("Some tests failed");
        $finish;
    end

    // result side: check each transfer, then pick the next ready level
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(kte_pkg::status_t'(m_tuser), kte_pkg::out_item_t'(m_tdata));
            m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
        end
    end

    function automatic kte_pkg::in_item_t rand_item();
        kte_pkg::in_item_t it;
        it.pad             = '0;
        it.symbol_care     = 16'($urandom);
        it.symbol_value    = 16'($urandom);
        it.range_count     = 9'($urandom_range(0, 256));
        it.range_start     = 8'($urandom);
        it.load_next_state = 6'($urandom);
        it.load_out_dash   = 16'($urandom);
        it.load_out_value  = 16'($urandom);
        it.pattern_care    = 16'($urandom);
        it.pattern_value   = 16'($urandom);
        it.state_index     = 6'($urandom);
        it.entry_index     = 8'($urandom);
        return it;
    endfunction

    function automatic int rand_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 6);
        if (r < 83) return 0;
        if (r < 90) return 256;
        return $urandom_range(0, 256);
    endfunction

    function automatic logic [5:0] pick_next();
        if ($urandom_range(0, 99) < 85) return hot_states[3'($urandom_range(0, 7))];
        return 6'($urandom_range(0, 63));
    endfunction

    task automatic send_item(kte_pkg::cmd_t c, kte_pkg::in_item_t it);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        s_tuser  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (!(c == kte_pkg::CMD_STEP && sb.halted)) work_items++;
        sb.note_input(c, it);
    endtask

    task automatic send_trans(logic [7:0] slot, logic [15:0] pv, logic [15:0] pc,
                              logic [15:0] ov, logic [15:0] od, logic [5:0] nxt);
        kte_pkg::in_item_t it;
        it = rand_item();
        it.entry_index     = slot;
        it.pattern_value   = pv;
        it.pattern_care    = pc;
        it.load_out_value  = ov;
        it.load_out_dash   = od;
        it.load_next_state = nxt;
        send_item(kte_pkg::CMD_WR_TRANS, it);
    endtask

    task automatic send_range(logic [5:0] st, logic [7:0] first, logic [8:0] cnt);
        kte_pkg::in_item_t it;
        it = rand_item();
        it.state_index = st;
        it.range_start = first;
        it.range_count = cnt;
        send_item(kte_pkg::CMD_WR_RANGE, it);
    endtask

    task automatic send_restart();
        send_item(kte_pkg::CMD_RESTART, rand_item());
    endtask

    task automatic send_step(logic [15:0] sv, logic [15:0] sc);
        kte_pkg::in_item_t it;
        it = rand_item();
        it.symbol_value = sv;
        it.symbol_care  = sc;
        send_item(kte_pkg::CMD_STEP, it);
    endtask

    task automatic send_trans_rand(logic [7:0] slot);
        logic [15:0] pc;
        logic [15:0] od;
        case ($urandom_range(0, 9))
            0:       pc = 16'hFFFF;
            1, 2:    pc = 16'($urandom);
            default: pc = 16'($urandom & $urandom & $urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       od = 16'h0;
            1:       od = 16'($urandom);
            default: od = 16'($urandom & $urandom);
        endcase
        send_trans(slot, 16'($urandom), pc, 16'($urandom), od, pick_next());
    endtask

    // fill in whatever the current state's scan would read before stepping
    task automatic make_steppable();
        logic [5:0] st;
        int         last;
        st = sb.cur_state;
        if (!sb.range_done[st])
            send_range(st, 8'($urandom_range(0, 255)), 9'(rand_count()));
        last = sb.scan_last(st);
        for (int i = sb.rng_first[st]; i < last; i++)
            if (!sb.slot_done[i]) send_trans_rand(8'(i));
    endtask

    task automatic send_rand_step();
        logic [15:0] sv;
        logic [15:0] sc;
        int          first;
        int          last;
        int          pick;
        first = sb.rng_first[sb.cur_state];
        last  = sb.scan_last(sb.cur_state);
        if (last > first && $urandom_range(0, 1)) begin
            pick = $urandom_range(first, last - 1);
            sv   = sb.pat_val[pick] ^ (16'($urandom) & ~sb.pat_care[pick]);
        end else begin
            sv = 16'($urandom);
        end
        case ($urandom_range(0, 9))
            0:       sc = 16'h0;
            1, 2:    sc = 16'($urandom);
            default: sc = 16'hFFFF;
        endcase
        send_step(sv, sc);
    endtask

    task automatic gen_one();
        int r;
        r = $urandom_range(0, 99);
        if (sb.halted) begin
            if (r < 75) send_restart();
            else send_step(16'($urandom), 16'($urandom));
        end else if (r < 5) begin
            send_trans_rand(8'($urandom_range(0, 255)));
        end else if (r < 8) begin
            send_range(6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                       9'(rand_count()));
        end else if (r < 11) begin
            send_restart();
        end else begin
            make_steppable();
            send_rand_step();
        end
    endtask

    task automatic program_regs(logic [5:0] st, logic [5:0] iw, logic [5:0] ow);
        logic [kte_pkg::CFG_IDX_W-1:0]  idx[3];
        logic [kte_pkg::CFG_DATA_W-1:0] val[3];
        idx = '{kte_pkg::CFG_START_STATE, kte_pkg::CFG_INPUT_WIDTH,
                kte_pkg::CFG_OUTPUT_WIDTH};
        val = '{st, iw, ow};
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // runs at input and output width 16 with start state 0
    task automatic run_directed();
        send_trans(8'd0,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 6'd1);
        send_trans(8'd1,   16'h0000, 16'hFFFF, 16'h1234, 16'hFF00, 6'd63);
        send_trans(8'd2,   16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 6'd2);
        send_trans(8'd255, 16'hA5A5, 16'hFFFF, 16'h8001, 16'h0000, 6'd0);
        send_range(6'd0,  8'd0,   9'd2);
        send_range(6'd1,  8'd255, 9'd256);   // clamped to the last slot
        send_range(6'd63, 8'd2,   9'd1);
        send_range(6'd2,  8'd0,   9'd0);     // empty range
        send_step(16'hFFFF, 16'hFFFF);
        send_step(16'hA5A5, 16'hFFFF);
        send_step(16'h0000, 16'hFFFF);       // first entry misses, second hits
        send_step(16'h5A5A, 16'hFFFF);       // all-dash pattern, dashed output
        send_step(16'h1234, 16'hFFFF);       // no match -> halt
        send_step(16'hFFFF, 16'hFFFF);       // ignored while halted
        send_restart();
        send_step(16'h5A5A, 16'h0000);       // dashed symbol matches anything
        send_step(16'h0000, 16'hFFFF);
        send_restart();
    endtask

    initial begin
        logic [5:0] st;
        logic [5:0] iw;
        logic [5:0] ow;
        int         target;
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        work_items = 0;
        s_idle_pct = 16;
        m_idle_pct = 57;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < 6; p++) begin
            case (p / 2)
                0:       begin s_idle_pct = 16; m_idle_pct = 57; end
                1:       begin s_idle_pct = 57; m_idle_pct = 16; end
                default: begin s_idle_pct = 0;  m_idle_pct = 0;  end
            endcase
            st = 6'($urandom_range(0, 63));
            iw = 6'($urandom_range(1, 16));
            ow = 6'($urandom_range(1, 16));
            case (p)
                0: begin st = 6'd0;  iw = 6'd16; ow = 6'd16; end
                1: begin st = 6'd63; iw = 6'd1;  ow = 6'd1;  end
                3: begin iw = 6'd16; ow = 6'd1;  end
                4: begin iw = 6'd1;  ow = 6'd16; end
                default: ;
            endcase
            program_regs(st, iw, ow);
            hot_states[0] = st;
            for (int i = 1; i < 8; i++) hot_states[i] = 6'($urandom_range(0, 63));
            if (p == 0) run_directed();
            target = work_items + 325;
            while (work_items < target) gen_one();
        end

        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("covered %0d steps, %0d table loads, %0d restarts over six width/start settings",
                 sb.n_steps, sb.n_loads, sb.n_restarts);
        $display("%0d results checked, %0d no-match halts, %0d mismatches",
                 sb.checked, sb.n_nomatch, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
